FILE: sv/two_link_inverse_kinematics_top_assert.svh
// Assertion macros shared by the kinematics RTL.
`ifndef TWO_LINK_INVERSE_KINEMATICS_TOP_ASSERT_SVH
`define TWO_LINK_INVERSE_KINEMATICS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLIK_ASSERT_NOW(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tlik assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TLIK_ASSERT_NEXT(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tlik assertion failed");

`endif

FILE: sv/tlik_pkg.sv
package tlik_pkg;

	localparam int LINK_BITS = 11;
	localparam int LEN_BITS = 12;
	localparam int CFG_IDX_BITS = 2;
	localparam logic [LINK_BITS-1:0] LINK_RESET = 11'd64;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_FIRST_LINK = 2'd0,
		CFG_SECOND_LINK = 2'd1
	} cfg_index_t;

	localparam int P11_BITS = 2 * LINK_BITS;
	localparam int PLL_BITS = 2 * LEN_BITS;
	localparam int P1L_BITS = LINK_BITS + LEN_BITS;

	// Law-of-cosines numerator and denominator widths.
	localparam int D_BITS = 25;
	localparam int N_BITS = D_BITS + 1;
	localparam int FRAC_BITS = 15;
	localparam int Q_BITS = 16;
	localparam int NUM_BITS = N_BITS + Q_BITS;

	localparam int C_BITS = 17;
	localparam logic signed [C_BITS-1:0] C_ONE = 17'sd32768;
	localparam int SRAD_BITS = 32;
	localparam logic [SRAD_BITS-1:0] SRAD_ONE = 32'h4000_0000;
	localparam int SINE_BITS = SRAD_BITS / 2;

	localparam int CORDIC_SCALE = 20;
	localparam int CORDIC_GUARD = 2;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

	typedef struct packed {
		logic far;
		logic close;
	} flags_t;

	typedef struct packed {
		logic [D_BITS-1:0] rem;
		logic [Q_BITS-1:0] low;
		logic satp;
		logic satn;
		logic neg;
	} div_prep_t;

	// Arctangent of 2^-i as a 32-bit fraction of a turn.
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'd536870912;
			1: t = 32'd316933406;
			2: t = 32'd167458907;
			3: t = 32'd85004756;
			4: t = 32'd42667331;
			5: t = 32'd21354465;
			6: t = 32'd10679838;
			7: t = 32'd5340245;
			8: t = 32'd2670163;
			9: t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			24: t = 32'd41;
			25: t = 32'd20;
			26: t = 32'd10;
			27: t = 32'd5;
			28: t = 32'd3;
			29: t = 32'd1;
			30: t = 32'd1;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

FILE: sv/tlik_sqrt_cell.sv
// One result bit of a digit-by-digit integer square root.
module tlik_sqrt_cell #(
	parameter int RW = 32,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v,
	input  logic [RW-1:0]    rad,
	input  logic [RW/2+2:0]  rem,
	input  logic [RW/2-1:0]  root,
	input  logic [SW-1:0]    side,
	output logic             v_q,
	output logic [RW-1:0]    rad_q,
	output logic [RW/2+2:0]  rem_q,
	output logic [RW/2-1:0]  root_q,
	output logic [SW-1:0]    side_q
);
	localparam int RHW = RW / 2;
	localparam int RMW = RHW + 3;

	logic [RMW-1:0] rem_sh;
	logic [RMW-1:0] trial;
	logic           ge;

	assign rem_sh = {rem[RMW-3:0], rad[RW-1:RW-2]};
	assign trial = {{(RMW-RHW-2){1'b0}}, root, 2'b01};
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= {rad[RW-3:0], 2'b00};
			rem_q <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root[RHW-2:0], ge};
			side_q <= side;
		end
	end
endmodule

FILE: sv/tlik_div_cell.sv
// One quotient bit of a restoring divider.
module tlik_div_cell #(
	parameter int DW = 25,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v,
	input  logic [DW-1:0] rem,
	input  logic [DW-1:0] d,
	input  logic [QW-1:0] low,
	input  logic [QW-1:0] q,
	input  logic [SW-1:0] side,
	output logic          v_q,
	output logic [DW-1:0] rem_q,
	output logic [DW-1:0] d_q,
	output logic [QW-1:0] low_q,
	output logic [QW-1:0] q_q,
	output logic [SW-1:0] side_q
);
	logic [DW:0] t;
	logic [DW:0] diff;
	logic        ge;

	assign t = {rem, low[QW-1]};
	assign ge = t >= {1'b0, d};
	assign diff = t - {1'b0, d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DW-1:0] : t[DW-1:0];
			d_q <= d;
			low_q <= {low[QW-2:0], 1'b0};
			q_q <= {q[QW-2:0], ge};
			side_q <= side;
		end
	end
endmodule

FILE: sv/tlik_cordic_cell.sv
// One vectoring rotation of a CORDIC arctangent.
module tlik_cordic_cell #(
	parameter int XW = 39,
	parameter int IDX = 0,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v,
	input  logic signed [XW-1:0] x,
	input  logic signed [XW-1:0] y,
	input  logic [31:0]          z,
	input  logic [SW-1:0]        side,
	output logic                 v_q,
	output logic signed [XW-1:0] x_q,
	output logic signed [XW-1:0] y_q,
	output logic [31:0]          z_q,
	output logic [SW-1:0]        side_q
);
	localparam logic [31:0] T = tlik_pkg::atan_turn(IDX);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic                 pos;

	assign xs = x >>> IDX;
	assign ys = y >>> IDX;
	assign pos = y > 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= pos ? x + ys : x - ys;
			y_q <= pos ? y - xs : y + xs;
			z_q <= pos ? z + T : z - T;
			side_q <= side;
		end
	end
endmodule

FILE: sv/two_link_inverse_kinematics_top.sv
// Channel  Handshake               Payload
// input    in_valid / in_ready     base_x, base_y, target_x, target_y
// output   out_valid / out_ready   first_angle, second_angle, out_of_reach, too_close
// config   cfg_we (no handshake)   cfg_index, cfg_data
//
// One transaction enters per cycle while the output side keeps up.
// A transaction passes the distance root cells, two 16-cell dividers,
// two 16-cell sine roots and the CORDIC cells.
// Reset clears every stage valid and loads both link lengths with 64.
// A stalled result freezes the whole pipeline, so in_ready is low while a result waits.
`include "two_link_inverse_kinematics_top_assert.svh"

module two_link_inverse_kinematics_top #(
	parameter int COORD_BITS = 12,
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tlik_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tlik_pkg::LINK_BITS-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_BITS-1:0]          base_x,
	input  logic signed [COORD_BITS-1:0]          base_y,
	input  logic signed [COORD_BITS-1:0]          target_x,
	input  logic signed [COORD_BITS-1:0]          target_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ANGLE_BITS-1:0]                 first_angle,
	output logic [ANGLE_BITS-1:0]                 second_angle,
	output logic                                  out_of_reach,
	output logic                                  too_close
);
	localparam int LB = tlik_pkg::LINK_BITS;
	localparam int EB = tlik_pkg::LEN_BITS;
	localparam int DB = tlik_pkg::D_BITS;
	localparam int NB = tlik_pkg::N_BITS;
	localparam int QB = tlik_pkg::Q_BITS;
	localparam int CB = tlik_pkg::C_BITS;
	localparam int SRB = tlik_pkg::SRAD_BITS;
	localparam int SNB = tlik_pkg::SINE_BITS;
	localparam int SCL = tlik_pkg::CORDIC_SCALE;
	localparam int GRD = tlik_pkg::CORDIC_GUARD;

	localparam int DXW = COORD_BITS + 1;
	localparam int RW = 2 * DXW;
	localparam int CW = (DXW > EB) ? DXW : EB;
	localparam int XWD = DXW + SCL + GRD;
	localparam int XWI = CB + SCL + GRD;
	localparam int PSW = 2 * DXW + 2;
	localparam int SH = 32 - ANGLE_BITS;
	localparam logic [32:0] HALF = (33'd1 << SH) >> 1;

	// Configuration registers.
	logic [LB-1:0] l1_cfg_q;
	logic [LB-1:0] l2_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_cfg_q <= tlik_pkg::LINK_RESET;
			l2_cfg_q <= tlik_pkg::LINK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tlik_pkg::CFG_FIRST_LINK: l1_cfg_q <= cfg_data;
				tlik_pkg::CFG_SECOND_LINK: l2_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A length written as zero acts as one. The user must change configuration only
	// while idle, as the stages read these directly; the block does not enforce it.
	logic [LB-1:0] l1;
	logic [LB-1:0] l2;
	logic [EB-1:0] lsum;
	assign l1 = (l1_cfg_q == '0) ? LB'(1) : l1_cfg_q;
	assign l2 = (l2_cfg_q == '0) ? LB'(1) : l2_cfg_q;
	assign lsum = EB'(l1) + EB'(l2);

	// The whole pipeline moves together whenever the output register can take a value.
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	function automatic tlik_pkg::div_prep_t div_prep(input logic signed [NB-1:0] n,
			input logic [DB-1:0] d);
		logic signed [NB-1:0] ds;
		logic [NB-1:0] mag;
		logic [tlik_pkg::NUM_BITS-1:0] num;
		tlik_pkg::div_prep_t r;
		ds = signed'({1'b0, d});
		r.satp = n > ds;
		r.satn = n < -ds;
		r.neg = n[NB-1];
		mag = r.neg ? -n : n;
		num = {1'b0, mag, {tlik_pkg::FRAC_BITS{1'b0}}}
			+ tlik_pkg::NUM_BITS'(d[DB-1:1]);
		r.rem = num[QB+DB-1:QB];
		r.low = num[QB-1:0];
		return r;
	endfunction

	// Stage valids.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	// Front end: differences, squares and their sum.
	logic signed [DXW-1:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [RW-1:0]  sqx_s2, sqy_s2;
	logic [RW-1:0]         sum_s3;

	// Distance root chain.
	logic            lr_v    [0:DXW];
	logic [RW-1:0]   lr_rad  [0:DXW];
	logic [RW/2+2:0] lr_rem  [0:DXW];
	logic [DXW-1:0]  lr_root [0:DXW];
	logic [2*DXW-1:0] lr_side [0:DXW];

	logic signed [DXW-1:0] dx_lr, dy_lr;
	logic [CW-1:0]         root_cw;
	assign {dx_lr, dy_lr} = lr_side[DXW];
	assign root_cw = CW'(lr_root[DXW]);

	// Clamp, products and the law-of-cosines terms.
	logic signed [DXW-1:0] dx_s4, dy_s4, dx_s5, dy_s5, dx_s6, dy_s6, dx_s7, dy_s7;
	tlik_pkg::flags_t      fl_s4, fl_s5, fl_s6, fl_s7;
	logic [EB-1:0]         len_s4;
	logic [tlik_pkg::P11_BITS-1:0] p11_s5, p22_s5, p12_s5;
	logic [tlik_pkg::PLL_BITS-1:0] pll_s5;
	logic [tlik_pkg::P1L_BITS-1:0] p1l_s5;
	logic signed [NB-1:0]  n1_s6, n2_s6;
	logic [DB-1:0]         d1_s6, d2_s6, d1_s7, d2_s7;
	tlik_pkg::div_prep_t   pr1_s7, pr2_s7;

	// Divider chains.
	logic           dv1_v [0:QB];
	logic [DB-1:0]  dv1_rem [0:QB];
	logic [DB-1:0]  dv1_d [0:QB];
	logic [QB-1:0]  dv1_low [0:QB];
	logic [QB-1:0]  dv1_q [0:QB];
	logic [PSW+2:0] dv1_side [0:QB];
	logic           dv2_v [0:QB];
	logic [DB-1:0]  dv2_rem [0:QB];
	logic [DB-1:0]  dv2_d [0:QB];
	logic [QB-1:0]  dv2_low [0:QB];
	logic [QB-1:0]  dv2_q [0:QB];
	logic [2:0]     dv2_side [0:QB];

	logic signed [DXW-1:0] dx_dv, dy_dv;
	tlik_pkg::flags_t      fl_dv;
	logic                  sp1, sn1, ng1, sp2, sn2, ng2;
	assign {dx_dv, dy_dv, fl_dv, sp1, sn1, ng1} = dv1_side[QB];
	assign {sp2, sn2, ng2} = dv2_side[QB];

	// Cosines, their squares and the sine radicands.
	logic signed [DXW-1:0]  dx_s8, dy_s8, dx_s9, dy_s9, dx_s10, dy_s10;
	tlik_pkg::flags_t       fl_s8, fl_s9, fl_s10;
	logic signed [CB-1:0]   c1_s8, c2_s8, c1_s9, c2_s9, c1_s10, c2_s10;
	logic signed [2*CB-1:0] cq1_s9, cq2_s9;
	logic [SRB-1:0]         sr1_s10, sr2_s10;

	// Sine root chains.
	logic              s1_v [0:SNB];
	logic [SRB-1:0]    s1_rad [0:SNB];
	logic [SRB/2+2:0]  s1_rem [0:SNB];
	logic [SNB-1:0]    s1_root [0:SNB];
	logic [PSW+CB-1:0] s1_side [0:SNB];
	logic              s2_v [0:SNB];
	logic [SRB-1:0]    s2_rad [0:SNB];
	logic [SRB/2+2:0]  s2_rem [0:SNB];
	logic [SNB-1:0]    s2_root [0:SNB];
	logic [CB-1:0]     s2_side [0:SNB];

	logic signed [DXW-1:0] dx_sn, dy_sn;
	tlik_pkg::flags_t      fl_sn;
	logic signed [CB-1:0]  c1_sn, c2_sn;
	assign {dx_sn, dy_sn, fl_sn, c1_sn} = s1_side[SNB];
	assign c2_sn = s2_side[SNB];

	// CORDIC chains: direction to the target and the two inner angles.
	logic                  cd_v [0:CORDIC_STAGES];
	logic signed [XWD-1:0] cd_x [0:CORDIC_STAGES];
	logic signed [XWD-1:0] cd_y [0:CORDIC_STAGES];
	logic [31:0]           cd_z [0:CORDIC_STAGES];
	logic [2:0]            cd_side [0:CORDIC_STAGES];
	logic                  ca_v [0:CORDIC_STAGES];
	logic signed [XWI-1:0] ca_x [0:CORDIC_STAGES];
	logic signed [XWI-1:0] ca_y [0:CORDIC_STAGES];
	logic [31:0]           ca_z [0:CORDIC_STAGES];
	logic                  ca_side [0:CORDIC_STAGES];
	logic                  cb_v [0:CORDIC_STAGES];
	logic signed [XWI-1:0] cb_x [0:CORDIC_STAGES];
	logic signed [XWI-1:0] cb_y [0:CORDIC_STAGES];
	logic [31:0]           cb_z [0:CORDIC_STAGES];
	logic                  cb_side [0:CORDIC_STAGES];

	logic signed [XWD-1:0] xd_w, yd_w;
	logic signed [XWI-1:0] xa_w, ya_w, xb_w, yb_w;
	assign xd_w = {{(XWD-DXW-SCL){dx_sn[DXW-1]}}, dx_sn, {SCL{1'b0}}};
	assign yd_w = {{(XWD-DXW-SCL){dy_sn[DXW-1]}}, dy_sn, {SCL{1'b0}}};
	assign xa_w = {{(XWI-CB-SCL){c1_sn[CB-1]}}, c1_sn, {SCL{1'b0}}};
	assign ya_w = {{(XWI-SNB-SCL){1'b0}}, s1_root[SNB], {SCL{1'b0}}};
	assign xb_w = {{(XWI-CB-SCL){c2_sn[CB-1]}}, c2_sn, {SCL{1'b0}}};
	assign yb_w = {{(XWI-SNB-SCL){1'b0}}, s2_root[SNB], {SCL{1'b0}}};

	logic                  zd_e, za_e, zb_e;
	tlik_pkg::flags_t      fl_cd;
	logic [31:0]           dir_e, ia_e, ib_e;
	assign {zd_e, fl_cd} = cd_side[CORDIC_STAGES];
	assign za_e = ca_side[CORDIC_STAGES];
	assign zb_e = cb_side[CORDIC_STAGES];
	assign dir_e = zd_e ? 32'd0 : cd_z[CORDIC_STAGES];
	assign ia_e = za_e ? 32'd0 : ca_z[CORDIC_STAGES];
	assign ib_e = zb_e ? 32'd0 : cb_z[CORDIC_STAGES];

	logic [31:0]      a1_s12, a2_s12;
	tlik_pkg::flags_t fl_s12;
	logic [31:0]      r1_w, r2_w;
	assign r1_w = a1_s12 + HALF[31:0];
	assign r2_w = a2_s12 + HALF[31:0];

	logic [ANGLE_BITS-1:0] ang1_q, ang2_q;
	logic                  far_q, close_q, out_v_q;

	// Stage valids and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= lr_v[DXW];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= dv1_v[QB] && dv2_v[QB];
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= s1_v[SNB] && s2_v[SNB];
			v_s12 <= cd_v[CORDIC_STAGES] && ca_v[CORDIC_STAGES] && cb_v[CORDIC_STAGES];
			out_v_q <= v_s12;
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DXW'(target_x) - DXW'(base_x);
			dy_s1 <= DXW'(target_y) - DXW'(base_y);

			sqx_s2 <= RW'(dx_s1) * RW'(dx_s1);
			sqy_s2 <= RW'(dy_s1) * RW'(dy_s1);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;

			sum_s3 <= sqx_s2 + sqy_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;

			// Clamp the distance to the reach, and raise zero to one.
			fl_s4.far <= root_cw > CW'(lsum);
			fl_s4.close <= root_cw == '0;
			if (root_cw > CW'(lsum)) begin
				len_s4 <= lsum;
			end else if (root_cw == '0) begin
				len_s4 <= EB'(1);
			end else begin
				len_s4 <= root_cw[EB-1:0];
			end
			dx_s4 <= dx_lr;
			dy_s4 <= dy_lr;

			p11_s5 <= tlik_pkg::P11_BITS'(l1) * tlik_pkg::P11_BITS'(l1);
			p22_s5 <= tlik_pkg::P11_BITS'(l2) * tlik_pkg::P11_BITS'(l2);
			p12_s5 <= tlik_pkg::P11_BITS'(l1) * tlik_pkg::P11_BITS'(l2);
			pll_s5 <= tlik_pkg::PLL_BITS'(len_s4) * tlik_pkg::PLL_BITS'(len_s4);
			p1l_s5 <= tlik_pkg::P1L_BITS'(l1) * tlik_pkg::P1L_BITS'(len_s4);
			dx_s5 <= dx_s4;
			dy_s5 <= dy_s4;
			fl_s5 <= fl_s4;

			n1_s6 <= signed'(NB'(p11_s5)) + signed'(NB'(pll_s5)) - signed'(NB'(p22_s5));
			n2_s6 <= signed'(NB'(p11_s5)) + signed'(NB'(p22_s5)) - signed'(NB'(pll_s5));
			d1_s6 <= DB'({p1l_s5, 1'b0});
			d2_s6 <= DB'({p12_s5, 1'b0});
			dx_s6 <= dx_s5;
			dy_s6 <= dy_s5;
			fl_s6 <= fl_s5;

			pr1_s7 <= div_prep(n1_s6, d1_s6);
			pr2_s7 <= div_prep(n2_s6, d2_s6);
			d1_s7 <= d1_s6;
			d2_s7 <= d2_s6;
			dx_s7 <= dx_s6;
			dy_s7 <= dy_s6;
			fl_s7 <= fl_s6;

			// Signed cosine, saturated where the triangle cannot close.
			if (sp1) begin
				c1_s8 <= tlik_pkg::C_ONE;
			end else if (sn1) begin
				c1_s8 <= -tlik_pkg::C_ONE;
			end else begin
				c1_s8 <= ng1 ? -signed'({1'b0, dv1_q[QB]}) : signed'({1'b0, dv1_q[QB]});
			end
			if (sp2) begin
				c2_s8 <= tlik_pkg::C_ONE;
			end else if (sn2) begin
				c2_s8 <= -tlik_pkg::C_ONE;
			end else begin
				c2_s8 <= ng2 ? -signed'({1'b0, dv2_q[QB]}) : signed'({1'b0, dv2_q[QB]});
			end
			fl_s8.far <= fl_dv.far;
			fl_s8.close <= fl_dv.close || sp1 || sn1 || sp2 || sn2;
			dx_s8 <= dx_dv;
			dy_s8 <= dy_dv;

			cq1_s9 <= c1_s8 * c1_s8;
			cq2_s9 <= c2_s8 * c2_s8;
			c1_s9 <= c1_s8;
			c2_s9 <= c2_s8;
			dx_s9 <= dx_s8;
			dy_s9 <= dy_s8;
			fl_s9 <= fl_s8;

			sr1_s10 <= tlik_pkg::SRAD_ONE - cq1_s9[SRB-1:0];
			sr2_s10 <= tlik_pkg::SRAD_ONE - cq2_s9[SRB-1:0];
			c1_s10 <= c1_s9;
			c2_s10 <= c2_s9;
			dx_s10 <= dx_s9;
			dy_s10 <= dy_s9;
			fl_s10 <= fl_s9;

			// Fold the left half plane onto the right one before the rotations.
			cd_x[0] <= dx_sn[DXW-1] ? -xd_w : xd_w;
			cd_y[0] <= dx_sn[DXW-1] ? -yd_w : yd_w;
			cd_z[0] <= dx_sn[DXW-1] ? tlik_pkg::HALF_TURN : 32'd0;
			cd_side[0] <= {(dx_sn == '0) && (dy_sn == '0), fl_sn};
			ca_x[0] <= c1_sn[CB-1] ? -xa_w : xa_w;
			ca_y[0] <= c1_sn[CB-1] ? -ya_w : ya_w;
			ca_z[0] <= c1_sn[CB-1] ? tlik_pkg::HALF_TURN : 32'd0;
			ca_side[0] <= (c1_sn == '0) && (s1_root[SNB] == '0);
			cb_x[0] <= c2_sn[CB-1] ? -xb_w : xb_w;
			cb_y[0] <= c2_sn[CB-1] ? -yb_w : yb_w;
			cb_z[0] <= c2_sn[CB-1] ? tlik_pkg::HALF_TURN : 32'd0;
			cb_side[0] <= (c2_sn == '0) && (s2_root[SNB] == '0);

			a1_s12 <= tlik_pkg::QUARTER_TURN + dir_e - ia_e;
			a2_s12 <= tlik_pkg::THREE_QUARTER_TURN + dir_e - ia_e - ib_e;
			fl_s12 <= fl_cd;

			// Round each angle half up to the output width.
			ang1_q <= r1_w[31 -: ANGLE_BITS];
			ang2_q <= r2_w[31 -: ANGLE_BITS];
			far_q <= fl_s12.far;
			close_q <= fl_s12.close;
		end
	end

	assign cd_v[0] = v_s11;
	assign ca_v[0] = v_s11;
	assign cb_v[0] = v_s11;

	// Chain heads.
	assign lr_v[0] = v_s3;
	assign lr_rad[0] = sum_s3;
	assign lr_rem[0] = '0;
	assign lr_root[0] = '0;
	assign lr_side[0] = {dx_s3, dy_s3};

	assign dv1_v[0] = v_s7;
	assign dv1_rem[0] = pr1_s7.rem;
	assign dv1_d[0] = d1_s7;
	assign dv1_low[0] = pr1_s7.low;
	assign dv1_q[0] = '0;
	assign dv1_side[0] = {dx_s7, dy_s7, fl_s7, pr1_s7.satp, pr1_s7.satn, pr1_s7.neg};
	assign dv2_v[0] = v_s7;
	assign dv2_rem[0] = pr2_s7.rem;
	assign dv2_d[0] = d2_s7;
	assign dv2_low[0] = pr2_s7.low;
	assign dv2_q[0] = '0;
	assign dv2_side[0] = {pr2_s7.satp, pr2_s7.satn, pr2_s7.neg};

	assign s1_v[0] = v_s10;
	assign s1_rad[0] = sr1_s10;
	assign s1_rem[0] = '0;
	assign s1_root[0] = '0;
	assign s1_side[0] = {dx_s10, dy_s10, fl_s10, c1_s10};
	assign s2_v[0] = v_s10;
	assign s2_rad[0] = sr2_s10;
	assign s2_rem[0] = '0;
	assign s2_root[0] = '0;
	assign s2_side[0] = c2_s10;

	for (genvar i = 0; i < DXW; i++) begin : g_len_root
		tlik_sqrt_cell #(.RW(RW), .SW(2 * DXW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(lr_v[i]), .rad(lr_rad[i]), .rem(lr_rem[i]), .root(lr_root[i]),
			.side(lr_side[i]),
			.v_q(lr_v[i+1]), .rad_q(lr_rad[i+1]), .rem_q(lr_rem[i+1]),
			.root_q(lr_root[i+1]), .side_q(lr_side[i+1])
		);
	end

	for (genvar i = 0; i < QB; i++) begin : g_div
		tlik_div_cell #(.DW(DB), .QW(QB), .SW(PSW + 3)) u_div1 (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(dv1_v[i]), .rem(dv1_rem[i]), .d(dv1_d[i]), .low(dv1_low[i]),
			.q(dv1_q[i]), .side(dv1_side[i]),
			.v_q(dv1_v[i+1]), .rem_q(dv1_rem[i+1]), .d_q(dv1_d[i+1]),
			.low_q(dv1_low[i+1]), .q_q(dv1_q[i+1]), .side_q(dv1_side[i+1])
		);
		tlik_div_cell #(.DW(DB), .QW(QB), .SW(3)) u_div2 (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(dv2_v[i]), .rem(dv2_rem[i]), .d(dv2_d[i]), .low(dv2_low[i]),
			.q(dv2_q[i]), .side(dv2_side[i]),
			.v_q(dv2_v[i+1]), .rem_q(dv2_rem[i+1]), .d_q(dv2_d[i+1]),
			.low_q(dv2_low[i+1]), .q_q(dv2_q[i+1]), .side_q(dv2_side[i+1])
		);
	end

	for (genvar i = 0; i < SNB; i++) begin : g_sine
		tlik_sqrt_cell #(.RW(SRB), .SW(PSW + CB)) u_sin1 (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(s1_v[i]), .rad(s1_rad[i]), .rem(s1_rem[i]), .root(s1_root[i]),
			.side(s1_side[i]),
			.v_q(s1_v[i+1]), .rad_q(s1_rad[i+1]), .rem_q(s1_rem[i+1]),
			.root_q(s1_root[i+1]), .side_q(s1_side[i+1])
		);
		tlik_sqrt_cell #(.RW(SRB), .SW(CB)) u_sin2 (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(s2_v[i]), .rad(s2_rad[i]), .rem(s2_rem[i]), .root(s2_root[i]),
			.side(s2_side[i]),
			.v_q(s2_v[i+1]), .rad_q(s2_rad[i+1]), .rem_q(s2_rem[i+1]),
			.root_q(s2_root[i+1]), .side_q(s2_side[i+1])
		);
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		tlik_cordic_cell #(.XW(XWD), .IDX(i), .SW(3)) u_dir (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(cd_v[i]), .x(cd_x[i]), .y(cd_y[i]), .z(cd_z[i]), .side(cd_side[i]),
			.v_q(cd_v[i+1]), .x_q(cd_x[i+1]), .y_q(cd_y[i+1]), .z_q(cd_z[i+1]),
			.side_q(cd_side[i+1])
		);
		tlik_cordic_cell #(.XW(XWI), .IDX(i), .SW(1)) u_in1 (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(ca_v[i]), .x(ca_x[i]), .y(ca_y[i]), .z(ca_z[i]), .side(ca_side[i]),
			.v_q(ca_v[i+1]), .x_q(ca_x[i+1]), .y_q(ca_y[i+1]), .z_q(ca_z[i+1]),
			.side_q(ca_side[i+1])
		);
		tlik_cordic_cell #(.XW(XWI), .IDX(i), .SW(1)) u_in2 (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v(cb_v[i]), .x(cb_x[i]), .y(cb_y[i]), .z(cb_z[i]), .side(cb_side[i]),
			.v_q(cb_v[i+1]), .x_q(cb_x[i+1]), .y_q(cb_y[i+1]), .z_q(cb_z[i+1]),
			.side_q(cb_side[i+1])
		);
	end

	assign out_valid = out_v_q;
	assign first_angle = ang1_q;
	assign second_angle = ang2_q;
	assign out_of_reach = far_q;
	assign too_close = close_q;

	// A finished angle pair that advances must show up at the output.
	`TLIK_ASSERT_NEXT(a_last_stage_delivers, clk, arst_n, adv && v_s12, out_valid)
	// A result held by the consumer must block new input transactions.
	`TLIK_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, out_valid && !out_ready, !in_ready)
	// A frozen pipeline keeps its stage contents.
	`TLIK_ASSERT_NEXT(a_freeze_holds, clk, arst_n, !adv, $stable(v_s1) && $stable(v_s12) && $stable(dx_s1))
endmodule
